// ===== rtl/kfv4_pkg.sv =====
package kfv4_pkg;

	localparam logic [1:0] OP_SET = 2'd0;
	localparam logic [1:0] OP_START = 2'd1;
	localparam logic [1:0] OP_EVAL = 2'd2;
	localparam logic [1:0] OP_NONE = 2'd3;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_REJECT = 2'd1;
	localparam logic [1:0] ST_SAT = 2'd2;

	localparam logic [16:0] STEP_ONE = 17'd65536;
	localparam logic signed [15:0] VAL_ONE = 16'sd4096;

	typedef struct packed {
		logic [1:0] operation;
		logic [16:0] position;
		logic signed [15:0] value_x;
		logic signed [15:0] value_y;
		logic signed [15:0] value_z;
		logic signed [15:0] value_w;
	} in_item_t;

	typedef struct packed {
		logic signed [15:0] out_x;
		logic signed [15:0] out_y;
		logic signed [15:0] out_z;
		logic signed [15:0] out_w;
		logic [1:0] status;
	} out_item_t;

	typedef struct packed {
		logic start;
		logic signed [33:0] num;
		logic [16:0] den;
	} div_req_t;

	typedef struct packed {
		logic busy;
		logic done;
		logic signed [33:0] quo;
	} div_rsp_t;

endpackage

// ===== rtl/kfv4_divider.sv =====
module kfv4_divider (
	input logic clk,
	input logic arst_n,
	input kfv4_pkg::div_req_t req,
	output kfv4_pkg::div_rsp_t rsp
);

	logic [33:0] rem_q;
	logic [33:0] quo_q;
	logic [16:0] den_q;
	logic neg_q;
	logic [5:0] cnt_q;
	logic busy_q;
	logic done_q;
	logic [33:0] mag;
	logic [17:0] trial;
	logic [33:0] part;

	assign mag = req.num[33] ? 34'(-req.num) : 34'(req.num);
	assign part = {rem_q[32:0], quo_q[33]};
	assign trial = {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= 6'd34;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= mag;
			den_q <= req.den;
			neg_q <= req.num[33];
		end else if (busy_q) begin
			if (part >= {16'd0, trial}) begin
				rem_q <= part - {16'd0, trial};
				quo_q <= {quo_q[32:0], 1'b1};
			end else begin
				rem_q <= part;
				quo_q <= {quo_q[32:0], 1'b0};
			end
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.quo = neg_q ? 34'(-quo_q) : quo_q;

endmodule

// ===== rtl/keyframe_vec4_interpolator.sv =====
// Steps: set searches the key table, then shifts later keys up and writes a new key; start
// loads the first segment; evaluate searches the table entries, loads a segment, then runs
// four divisions on the shared serial divider and fills the result register.
// Throughput: one item at a time; ready is low from acceptance until the result is formed.
// A result waiting for transfer stalls only the forming of the next result, not its input.
// Reset: asynchronous, active low; table holds keys 0 and 1.0 with value 1.0.
module keyframe_vec4_interpolator #(
	parameter int MAX_KEYS = 16
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input kfv4_pkg::in_item_t in_data,
	output logic out_valid,
	input logic out_ready,
	output kfv4_pkg::out_item_t out_data
);

	localparam int IW = $clog2(MAX_KEYS);
	localparam int CW = $clog2(MAX_KEYS + 1);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_FIND = 4'd1;
	localparam logic [3:0] S_SHIFT = 4'd2;
	localparam logic [3:0] S_WRITE = 4'd3;
	localparam logic [3:0] S_LOADA = 4'd4;
	localparam logic [3:0] S_LOADB = 4'd5;
	localparam logic [3:0] S_SRCH = 4'd6;
	localparam logic [3:0] S_DIVGO = 4'd7;
	localparam logic [3:0] S_DIVW = 4'd8;
	localparam logic [3:0] S_OUT = 4'd9;

	logic [3:0] state_q;
	logic [16:0] steps_q [MAX_KEYS];
	logic [63:0] vals_q [MAX_KEYS];
	logic [CW-1:0] count_q;
	logic [16:0] s0_q, s1_q;
	logic [63:0] v0_q, v1_q;
	logic [IW-1:0] endi_q;
	kfv4_pkg::in_item_t item_q;
	logic [16:0] p_q;
	logic sat_q;
	logic [1:0] stat_q;
	logic [CW-1:0] idx_q;
	logic [1:0] comp_q;
	logic [63:0] res_q;
	logic obusy_q;
	kfv4_pkg::out_item_t out_q;
	kfv4_pkg::div_req_t dreq;
	kfv4_pkg::div_rsp_t drsp;
	logic signed [15:0] a_c, b_c;
	logic signed [16:0] dv;
	logic signed [17:0] dp;
	logic signed [33:0] prod;
	logic signed [34:0] sum;
	logic signed [15:0] clip;
	logic clipped;
	logic [IW-1:0] idx;
	logic [IW-1:0] idxm1;
	logic [63:0] newv;

	assign idx = idx_q[IW-1:0];
	assign idxm1 = IW'(idx_q - CW'(1));
	assign newv = {item_q.value_x, item_q.value_y, item_q.value_z, item_q.value_w};
	assign a_c = v0_q[63 - 16 * comp_q -: 16];
	assign b_c = v1_q[63 - 16 * comp_q -: 16];
	assign dv = 17'(b_c) - 17'(a_c);
	assign dp = $signed({1'b0, p_q}) - $signed({1'b0, s0_q});
	assign prod = 34'(dv * dp);
	assign dreq.start = (state_q == S_DIVGO) && (s1_q > s0_q);
	assign dreq.num = prod;
	assign dreq.den = s1_q - s0_q;
	assign sum = 35'(a_c) + ((s1_q > s0_q) ? 35'(drsp.quo) : 35'sd0);
	always_comb begin
		clipped = 1'b0;
		clip = sum[15:0];
		if (sum > 35'sd32767) begin
			clip = 16'sd32767;
			clipped = 1'b1;
		end else if (sum < -35'sd32768) begin
			clip = -16'sd32768;
			clipped = 1'b1;
		end
	end

	kfv4_divider u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));

	assign in_ready = (state_q == S_IDLE);
	assign out_valid = obusy_q;
	assign out_data = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			obusy_q <= 1'b0;
			count_q <= CW'(2);
			steps_q[0] <= '0;
			steps_q[1] <= kfv4_pkg::STEP_ONE;
			vals_q[0] <= {4{kfv4_pkg::VAL_ONE}};
			vals_q[1] <= {4{kfv4_pkg::VAL_ONE}};
			s0_q <= '0;
			s1_q <= '0;
			v0_q <= '0;
			v1_q <= '0;
			endi_q <= '0;
		end else begin
			if (state_q == S_OUT && (!obusy_q || out_ready)) begin
				obusy_q <= 1'b1;
			end else if (out_ready) begin
				obusy_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid && in_ready) begin
						item_q <= in_data;
						idx_q <= (in_data.operation == kfv4_pkg::OP_EVAL) ?
							CW'(endi_q) + CW'(1) : '0;
						comp_q <= '0;
						stat_q <= (in_data.operation == kfv4_pkg::OP_SET &&
							in_data.position > kfv4_pkg::STEP_ONE) ?
							kfv4_pkg::ST_REJECT : kfv4_pkg::ST_OK;
						sat_q <= in_data.position > kfv4_pkg::STEP_ONE;
						p_q <= (in_data.position > kfv4_pkg::STEP_ONE) ?
							kfv4_pkg::STEP_ONE : in_data.position;
						unique case (in_data.operation)
							kfv4_pkg::OP_SET: begin
								if (in_data.position > kfv4_pkg::STEP_ONE) begin
									state_q <= S_OUT;
								end else begin
									state_q <= S_FIND;
								end
							end
							kfv4_pkg::OP_START: state_q <= S_LOADA;
							kfv4_pkg::OP_EVAL: state_q <= S_SRCH;
							default: state_q <= S_OUT;
						endcase
					end
				end
				S_FIND: begin
					if (idx_q < count_q && steps_q[idx] < item_q.position) begin
						idx_q <= idx_q + CW'(1);
					end else if (idx_q < count_q && steps_q[idx] == item_q.position) begin
						vals_q[idx] <= newv;
						state_q <= S_OUT;
					end else if (count_q >= CW'(MAX_KEYS)) begin
						stat_q <= kfv4_pkg::ST_REJECT;
						state_q <= S_OUT;
					end else begin
						comp_q <= '0;
						state_q <= S_SHIFT;
						res_q <= {{(64 - CW){1'b0}}, count_q};
					end
				end
				S_SHIFT: begin
					if (res_q[CW-1:0] > idx_q) begin
						steps_q[res_q[IW-1:0]] <= steps_q[IW'(res_q[CW-1:0] - CW'(1))];
						vals_q[res_q[IW-1:0]] <= vals_q[IW'(res_q[CW-1:0] - CW'(1))];
						res_q <= res_q - 64'd1;
					end else begin
						state_q <= S_WRITE;
					end
				end
				S_WRITE: begin
					steps_q[idx] <= item_q.position;
					vals_q[idx] <= newv;
					count_q <= count_q + CW'(1);
					state_q <= S_OUT;
				end
				S_LOADA: begin
					idx_q <= CW'(1);
					state_q <= S_LOADB;
				end
				S_LOADB: begin
					s0_q <= steps_q[idxm1];
					v0_q <= vals_q[idxm1];
					s1_q <= steps_q[idx];
					v1_q <= vals_q[idx];
					endi_q <= idx;
					state_q <= (item_q.operation == kfv4_pkg::OP_EVAL) ? S_DIVGO : S_OUT;
				end
				S_SRCH: begin
					if (p_q <= s1_q || idx_q >= count_q) begin
						state_q <= S_DIVGO;
					end else if (steps_q[idx] >= p_q) begin
						state_q <= S_LOADB;
					end else begin
						idx_q <= idx_q + CW'(1);
					end
				end
				S_DIVGO: state_q <= S_DIVW;
				S_DIVW: begin
					if (!drsp.busy && !dreq.start) begin
						res_q[63 - 16 * comp_q -: 16] <= clip;
						if (clipped) sat_q <= 1'b1;
						if (comp_q == 2'd3) begin
							state_q <= S_OUT;
							stat_q <= (sat_q || clipped) ?
								kfv4_pkg::ST_SAT : kfv4_pkg::ST_OK;
						end else begin
							comp_q <= comp_q + 2'd1;
							state_q <= S_DIVGO;
						end
					end
				end
				S_OUT: begin
					if (!obusy_q || out_ready) begin
						if (item_q.operation == kfv4_pkg::OP_EVAL) begin
							out_q <= kfv4_pkg::out_item_t'({res_q, stat_q});
						end else begin
							out_q <= kfv4_pkg::out_item_t'({64'd0, stat_q});
						end
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> state_q == S_IDLE) else $error("ready outside idle");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q >= CW'(2) && count_q <= CW'(MAX_KEYS)) else $error("key count range");
	a_out_after: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q) == S_OUT) else $error("spurious result");

endmodule

// ===== bench/kfv4_checker.sv =====
`timescale 1ns / 1ps

module kfv4_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input kfv4_pkg::in_item_t in_data,
	input logic out_valid,
	input logic out_ready,
	input kfv4_pkg::out_item_t out_data,
	output int fail_count,
	output int pending_count
);

	localparam int KEY_DEPTH = 16;

	logic [16:0] step_tbl [KEY_DEPTH];
	logic signed [15:0] val_tbl [KEY_DEPTH][4];
	int key_cnt;
	logic [16:0] seg_s0;
	logic [16:0] seg_s1;
	logic signed [15:0] seg_v0 [4];
	logic signed [15:0] seg_v1 [4];
	int seg_idx;
	kfv4_pkg::out_item_t frame_queue [$];

	function automatic kfv4_pkg::out_item_t interpolate_item(kfv4_pkg::in_item_t it);
		kfv4_pkg::out_item_t r;
		logic signed [15:0] nv [4];
		longint p;
		longint acc;
		longint dv;
		int slot;
		int i;
		bit sat;
		r = '0;
		nv[0] = it.value_x;
		nv[1] = it.value_y;
		nv[2] = it.value_z;
		nv[3] = it.value_w;
		if (it.operation == kfv4_pkg::OP_SET) begin
			if (it.position > kfv4_pkg::STEP_ONE) begin
				r.status = kfv4_pkg::ST_REJECT;
			end else begin
				slot = key_cnt;
				for (i = 0; i < key_cnt; i++) begin
					if (step_tbl[i] >= it.position) begin
						slot = i;
						break;
					end
				end
				if (slot < key_cnt && step_tbl[slot] == it.position) begin
					for (i = 0; i < 4; i++) val_tbl[slot][i] = nv[i];
				end else if (key_cnt >= KEY_DEPTH) begin
					r.status = kfv4_pkg::ST_REJECT;
				end else begin
					for (i = key_cnt; i > slot; i--) begin
						step_tbl[i] = step_tbl[i - 1];
						val_tbl[i] = val_tbl[i - 1];
					end
					step_tbl[slot] = it.position;
					for (i = 0; i < 4; i++) val_tbl[slot][i] = nv[i];
					key_cnt++;
				end
			end
		end else if (it.operation == kfv4_pkg::OP_START) begin
			seg_s0 = step_tbl[0];
			seg_s1 = step_tbl[1];
			seg_v0 = val_tbl[0];
			seg_v1 = val_tbl[1];
			seg_idx = 1;
		end else if (it.operation == kfv4_pkg::OP_EVAL) begin
			p = it.position;
			sat = 0;
			if (p > kfv4_pkg::STEP_ONE) begin
				p = kfv4_pkg::STEP_ONE;
				sat = 1;
			end
			if (p > seg_s1) begin
				for (i = seg_idx + 1; i < key_cnt; i++) begin
					if (step_tbl[i] >= p) begin
						seg_s0 = step_tbl[i - 1];
						seg_s1 = step_tbl[i];
						seg_v0 = val_tbl[i - 1];
						seg_v1 = val_tbl[i];
						seg_idx = i;
						break;
					end
				end
			end
			for (i = 0; i < 4; i++) begin
				acc = seg_v0[i];
				if (seg_s1 > seg_s0) begin
					dv = longint'(seg_v1[i]) - longint'(seg_v0[i]);
					acc += (dv * (p - longint'(seg_s0))) / (longint'(seg_s1) - longint'(seg_s0));
				end
				if (acc > 32767) begin
					acc = 32767;
					sat = 1;
				end
				if (acc < -32768) begin
					acc = -32768;
					sat = 1;
				end
				nv[i] = acc[15:0];
			end
			r.out_x = nv[0];
			r.out_y = nv[1];
			r.out_z = nv[2];
			r.out_w = nv[3];
			r.status = sat ? kfv4_pkg::ST_SAT : kfv4_pkg::ST_OK;
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		kfv4_pkg::out_item_t exp_item;
		int errs;
		if (!arst_n) begin
			fail_count <= 0;
			pending_count <= 0;
			frame_queue.delete();
			key_cnt = 2;
			step_tbl[0] = '0;
			step_tbl[1] = kfv4_pkg::STEP_ONE;
			for (int c = 0; c < 4; c++) begin
				val_tbl[0][c] = kfv4_pkg::VAL_ONE;
				val_tbl[1][c] = kfv4_pkg::VAL_ONE;
				seg_v0[c] = '0;
				seg_v1[c] = '0;
			end
			seg_s0 = '0;
			seg_s1 = '0;
			seg_idx = 0;
		end else begin
			errs = 0;
			if (out_valid && out_ready) begin
				if (frame_queue.size() == 0) begin
					$error("Result transfer with no expectation waiting");
					errs++;
				end else begin
					exp_item = frame_queue.pop_front();
					if (out_data.out_x !== exp_item.out_x) begin
						$error("out_x expected %0d actual %0d", exp_item.out_x, out_data.out_x);
						errs++;
					end
					if (out_data.out_y !== exp_item.out_y) begin
						$error("out_y expected %0d actual %0d", exp_item.out_y, out_data.out_y);
						errs++;
					end
					if (out_data.out_z !== exp_item.out_z) begin
						$error("out_z expected %0d actual %0d", exp_item.out_z, out_data.out_z);
						errs++;
					end
					if (out_data.out_w !== exp_item.out_w) begin
						$error("out_w expected %0d actual %0d", exp_item.out_w, out_data.out_w);
						errs++;
					end
					if (out_data.status !== exp_item.status) begin
						$error("status expected %0d actual %0d", exp_item.status, out_data.status);
						errs++;
					end
				end
			end
			if (in_valid && in_ready) begin
				frame_queue = {frame_queue, interpolate_item(in_data)};
			end
			fail_count <= fail_count + errs;
			pending_count <= frame_queue.size();
		end
	end
endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

	localparam int RANDOM_ITEMS = 1900;
	localparam longint CYCLE_LIMIT = 2000000;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	kfv4_pkg::in_item_t in_data;
	logic out_valid;
	logic out_ready;
	kfv4_pkg::out_item_t out_data;
	int fail_count;
	int pending_count;
	int send_idle_pct;
	int recv_idle_pct;
	bit hold_off;
	longint cycle_count;

	keyframe_vec4_interpolator i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

	kfv4_checker i_checker (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.fail_count(fail_count),
		.pending_count(pending_count)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	always @(negedge clk) begin
		if (!arst_n || hold_off) begin
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	function automatic logic signed [15:0] rand_value();
		case ($urandom_range(5))
			0: return 16'sh7FFF;
			1: return 16'sh8000;
			2: return 16'($urandom_range(8192) - 4096);
			default: return 16'($urandom());
		endcase
	endfunction

	function automatic logic [16:0] rand_step();
		case ($urandom_range(9))
			0: return 17'd0;
			1: return kfv4_pkg::STEP_ONE;
			2: return 17'(kfv4_pkg::STEP_ONE + $urandom_range(65535));
			3: return 17'($urandom_range(16) * 4096);
			default: return 17'($urandom_range(65536));
		endcase
	endfunction

	task automatic send_item(logic [1:0] op, logic [16:0] pos, logic signed [15:0] vx,
			logic signed [15:0] vy, logic signed [15:0] vz, logic signed [15:0] vw);
		while ($urandom_range(99) < send_idle_pct) @(negedge clk);
		in_valid = 1'b1;
		in_data = '{op, pos, vx, vy, vz, vw};
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	task automatic send_random();
		int pick;
		pick = $urandom_range(99);
		if (pick < 30) begin
			send_item(kfv4_pkg::OP_SET, rand_step(), rand_value(), rand_value(), rand_value(),
				rand_value());
		end else if (pick < 40) begin
			send_item(kfv4_pkg::OP_START, 17'($urandom()), 16'($urandom()), 16'($urandom()),
				16'($urandom()), 16'($urandom()));
		end else if (pick < 97) begin
			send_item(kfv4_pkg::OP_EVAL, rand_step(), 16'($urandom()), 16'($urandom()),
				16'($urandom()), 16'($urandom()));
		end else begin
			send_item(kfv4_pkg::OP_NONE, 17'($urandom()), 16'($urandom()), 16'($urandom()),
				16'($urandom()), 16'($urandom()));
		end
	endtask

	task automatic wait_drained();
		while (pending_count != 0) @(negedge clk);
		repeat (200) @(negedge clk);
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		hold_off = 1'b0;
		cycle_count = 0;
		send_idle_pct = 13;
		recv_idle_pct = 57;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;

		send_item(kfv4_pkg::OP_EVAL, 17'd100, '0, '0, '0, '0);
		send_item(kfv4_pkg::OP_START, '0, '0, '0, '0, '0);
		send_item(kfv4_pkg::OP_EVAL, 17'd0, '0, '0, '0, '0);
		send_item(kfv4_pkg::OP_EVAL, 17'd32768, '0, '0, '0, '0);
		send_item(kfv4_pkg::OP_EVAL, 17'h1FFFF, '0, '0, '0, '0);
		send_item(kfv4_pkg::OP_SET, 17'h1FFFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
		send_item(kfv4_pkg::OP_SET, 17'd65537, '0, '0, '0, '0);
		send_item(kfv4_pkg::OP_SET, 17'd0, 16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh0);
		send_item(kfv4_pkg::OP_SET, kfv4_pkg::STEP_ONE, 16'sh7FFF, 16'sh7FFF, 16'sh8000,
			16'shFFFF);
		send_item(kfv4_pkg::OP_SET, 17'd1, 16'sh7FFF, 16'sh8000, 16'sh1234, 16'shEDCB);
		send_item(kfv4_pkg::OP_START, '0, '0, '0, '0, '0);
		send_item(kfv4_pkg::OP_EVAL, 17'd2, '0, '0, '0, '0);
		send_item(kfv4_pkg::OP_EVAL, 17'd40000, '0, '0, '0, '0);
		send_item(kfv4_pkg::OP_EVAL, 17'd10, '0, '0, '0, '0);
		send_item(kfv4_pkg::OP_NONE, 17'h1FFFF, 16'shFFFF, 16'shFFFF, 16'shFFFF, 16'shFFFF);
		for (int k = 0; k < 15; k++) begin
			send_item(kfv4_pkg::OP_SET, 17'd2 + 17'(k) * 17'd4000, 16'sh7FFF, 16'sh8000,
				16'sh4000, 16'shC000);
		end
		send_item(kfv4_pkg::OP_SET, 17'd2, 16'sh0, 16'sh0, 16'sh0, 16'sh0);
		send_item(kfv4_pkg::OP_START, '0, '0, '0, '0, '0);
		send_item(kfv4_pkg::OP_EVAL, kfv4_pkg::STEP_ONE, '0, '0, '0, '0);

		fork
			begin
				hold_off = 1'b1;
				repeat (3000) @(negedge clk);
				hold_off = 1'b0;
			end
			for (int n = 0; n < 6; n++) send_random();
		join

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n == RANDOM_ITEMS / 3) begin
				send_idle_pct = 57;
				recv_idle_pct = 13;
			end else if (n == 2 * RANDOM_ITEMS / 3) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			if (n % 150 == 0) begin
				wait_drained();
			end
			send_random();
		end

		wait_drained();
		if (fail_count == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end
endmodule
